// ===== sv/iss_pkg.sv =====
`timescale 1ns / 1ps
// iss_pkg: shared types, constants and address helper for indexed_sequence_store.
// No dependencies.
package iss_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 11;
    localparam int VAL_W    = 32;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 48;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_ROTATE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_FETCH,
        S_DONE
    } state_t;

    // physical slot of logical index k, circular over CAPACITY entries
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  k);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(k);
        if (sum >= (CNT_W+1)'(CAPACITY)) begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== sv/indexed_sequence_store.sv =====
`timescale 1ns / 1ps
// indexed_sequence_store: ordered list of signed 32-bit values in a circular RAM.
// Depends on iss_pkg.
//
// Usage:
//   s_ channel carries one request: insert, delete, rotate or read by position.
//   m_ channel returns exactly one result per request: read value, status, length.
//   Requests are processed one at a time; s_tready is high only while idle.
//   After the accepting edge a request passes S_DECODE, then S_FETCH for read and
//   rotate or S_SHIFT for insert and delete (neither for a rejected request or an
//   empty rotate), then S_DONE, which raises m_tvalid; S_SHIFT copies moves
//   elements, where moves is count - pos + 1 for insert and count - pos for delete,
//   at most 1023. s_tready rises with m_tvalid.
//   The shift is set by the element RAM: one read port and one write port,
//   one element moved per cycle, pipelined across the read latency.
//   A result waiting in the output register does not block the next request;
//   that request only waits at its end until the output register is free.
//   Reset (aresetn low, synchronous) empties the list and sets the head to
//   slot 0; RAM contents are not cleared and stay unreadable until written.
//   Back-pressure on m_tready holds the result stable in m_tdata.
module indexed_sequence_store (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [iss_pkg::IN_W-1:0]  s_tdata,  // operation, position, value, direction
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [iss_pkg::OUT_W-1:0] m_tdata   // read_value, status, length
);
    import iss_pkg::*;

    logic [VAL_W-1:0] mem [CAPACITY];

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic              dir_reg, dir_next;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [CNT_W-1:0]  src_reg, src_next;
    logic [CNT_W-1:0]  moves_reg, moves_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;

    logic [VAL_W-1:0]  res_value_reg, res_value_next;
    status_t           res_status_reg, res_status_next;

    logic              m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]  out_value_reg, out_value_next;
    status_t           out_status_reg, out_status_next;
    logic [CNT_W-1:0]  out_len_reg, out_len_next;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [VAL_W-1:0]  rdata_reg;
    logic              we;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;

    logic              full;
    logic              pos_bad_ins;
    logic              pos_bad;
    logic              shift_done;
    logic              out_free;
    logic [CNT_W-1:0]  dst;
    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] head_inc;

    assign full        = (count_reg == CNT_W'(CAPACITY));
    assign pos_bad_ins = (pos_reg == '0) || ({1'b0, pos_reg} > ({1'b0, count_reg} + 1'b1));
    assign pos_bad     = (pos_reg == '0) || (pos_reg > count_reg);
    assign shift_done  = (moves_reg == '0) && !wr_pend_reg;
    assign out_free    = !m_valid_reg || m_tready;
    assign dst         = (op_reg == OP_INSERT) ? src_reg + 1'b1 : src_reg - 1'b1;
    assign head_dec    = (head_reg == '0) ? ADDR_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc    = (head_reg == ADDR_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_len_reg, out_status_reg, out_value_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (op_reg)
                    OP_INSERT: state_next = (full || pos_bad_ins) ? S_DONE : S_SHIFT;
                    OP_DELETE: state_next = pos_bad ? S_DONE : S_SHIFT;
                    OP_ROTATE: state_next = (count_reg == '0) ? S_DONE : S_FETCH;
                    OP_READ:   state_next = pos_bad ? S_DONE : S_FETCH;
                    default:   state_next = S_DONE;
                endcase
            end
            S_SHIFT: begin
                if (shift_done) begin
                    state_next = S_DONE;
                end
            end
            S_FETCH: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        op_next         = op_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        dir_next        = dir_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        src_next        = src_reg;
        moves_next      = moves_reg;
        wr_pend_next    = wr_pend_reg;
        wr_addr_next    = wr_addr_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        we              = 1'b0;
        wr_addr         = wr_addr_reg;
        wr_data         = rdata_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next  = op_t'(s_tdata[1:0]);
                    pos_next = s_tdata[12:2];
                    val_next = s_tdata[44:13];
                    dir_next = s_tdata[45];
                end
            end
            S_DECODE: begin
                res_value_next  = '0;
                res_status_next = ST_OK;
                wr_pend_next    = 1'b0;
                unique case (op_reg)
                    OP_INSERT: begin
                        if (full) begin
                            res_status_next = ST_FULL;
                        end else if (pos_bad_ins) begin
                            res_status_next = ST_RANGE;
                        end
                        src_next   = count_reg - 1'b1;
                        moves_next = count_reg - pos_reg + 1'b1;
                    end
                    OP_DELETE: begin
                        if (pos_bad) begin
                            res_status_next = ST_RANGE;
                        end
                        src_next   = pos_reg;
                        moves_next = count_reg - pos_reg;
                    end
                    OP_ROTATE: begin
                        rd_en   = (count_reg != '0);
                        rd_addr = dir_reg ? slot_of(head_reg, count_reg - 1'b1) : head_reg;
                    end
                    OP_READ: begin
                        if (pos_bad) begin
                            res_status_next = ST_RANGE;
                        end
                        rd_en   = !pos_bad;
                        rd_addr = slot_of(head_reg, pos_reg - 1'b1);
                    end
                    default: ;
                endcase
            end
            S_SHIFT: begin
                if (wr_pend_reg) begin
                    we      = 1'b1;
                    wr_addr = wr_addr_reg;
                    wr_data = rdata_reg;
                end
                if (moves_reg != '0) begin
                    rd_en        = 1'b1;
                    rd_addr      = slot_of(head_reg, src_reg);
                    wr_addr_next = slot_of(head_reg, dst);
                    src_next     = (op_reg == OP_INSERT) ? src_reg - 1'b1 : src_reg + 1'b1;
                    moves_next   = moves_reg - 1'b1;
                    wr_pend_next = 1'b1;
                end else begin
                    wr_pend_next = 1'b0;
                end
                if (shift_done) begin
                    if (op_reg == OP_INSERT) begin
                        we         = 1'b1;
                        wr_addr    = slot_of(head_reg, pos_reg - 1'b1);
                        wr_data    = val_reg;
                        count_next = count_reg + 1'b1;
                    end else begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            S_FETCH: begin
                if (op_reg == OP_ROTATE) begin
                    we      = 1'b1;
                    wr_data = rdata_reg;
                    if (dir_reg) begin
                        wr_addr   = head_dec;
                        head_next = head_dec;
                    end else begin
                        wr_addr   = slot_of(head_reg, count_reg);
                        head_next = head_inc;
                    end
                end else begin
                    res_value_next = rdata_reg;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_len_next    = count_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            moves_reg   <= '0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            moves_reg   <= moves_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        dir_reg        <= dir_next;
        src_reg        <= src_next;
        wr_addr_reg    <= wr_addr_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
    end

    // element RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule
